FILE: sv/catmull_rom_path_eval_defines.svh
// Assertion macros shared by the path evaluator modules.
// Depends on nothing; taken in by `include where assertions are written.
`ifndef CATMULL_ROM_PATH_EVAL_DEFINES_SVH
`define CATMULL_ROM_PATH_EVAL_DEFINES_SVH

// Assert that a condition implies a consequence in the same cycle.
`define CRP_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// Assert that a condition implies a consequence in the next cycle.
`define CRP_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/crp_pkg.sv
// Shared types and constants for the Catmull-Rom path evaluator.
// No dependencies.
`timescale 1ns / 1ps
package crp_pkg;
  localparam int unsigned CountWidth = 7;
  localparam int unsigned PtWidth    = 18;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_EVAL  = 1'b1
  } cmd_t;

  // Kind of evaluation the front end classified.
  typedef enum logic [1:0] {
    EV_ZERO   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_CURVE  = 2'd2
  } ev_kind_t;
endpackage

FILE: sv/catmull_rom_path_eval.sv
// Catmull-Rom path evaluator top level: front end, request register, three axes.
// Evaluate path: request register, point reads, axis Horner pipeline, out_valid.
// Throughput: one request per cycle; busy is tied low, writes and evaluates mix freely.
// The rate is set by one multiplier per Horner stage and two-copy point memories.
// Reset (rst_n low, synchronous) clears point_count and all strobes; points are kept.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`include "catmull_rom_path_eval_defines.svh"
module catmull_rom_path_eval #(
  parameter int unsigned MAX_POINTS  = 64,
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned T_FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_cmd,
  input  logic [5:0]                           in_point_index,
  input  logic signed [COORD_WIDTH-1:0]        in_point_x,
  input  logic signed [COORD_WIDTH-1:0]        in_point_y,
  input  logic signed [COORD_WIDTH-1:0]        in_point_z,
  input  logic signed [crp_pkg::PtWidth-1:0]   in_param_t,
  input  logic                                 cfg_we,
  input  logic [crp_pkg::CountWidth-1:0]       cfg_wdata,
  output logic                                 out_valid,
  output logic signed [COORD_WIDTH-1:0]        out_pos_x,
  output logic signed [COORD_WIDTH-1:0]        out_pos_y,
  output logic signed [COORD_WIDTH-1:0]        out_pos_z
);
  localparam int unsigned IDX_W = $clog2(MAX_POINTS);

  logic [crp_pkg::CountWidth-1:0] count_r;
  logic take, wr_en;
  logic [IDX_W-1:0] wr_idx;

  assign busy  = 1'b0;
  assign take  = start && !busy;
  assign wr_en = take && (in_cmd == crp_pkg::CMD_WRITE) && (32'(in_point_index) < MAX_POINTS);
  assign wr_idx = IDX_W'(in_point_index);

  // Hold the point count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_we) begin
      count_r <= cfg_wdata;
    end
  end

  logic q_valid_r;
  crp_pkg::ev_kind_t q_kind_r;
  logic [IDX_W-1:0] q_i0_r, q_i1_r, q_i2_r, q_i3_r;
  logic [T_FRAC_BITS:0] q_u_r;

  crp_front #(.MAX_POINTS(MAX_POINTS), .T_FRAC_BITS(T_FRAC_BITS), .IDX_W(IDX_W)) u_front (
    .clk(clk), .rst_n(rst_n), .take(take), .cmd(in_cmd),
    .param_t(in_param_t), .point_count(count_r),
    .q_valid_r(q_valid_r), .q_kind_r(q_kind_r),
    .q_i0_r(q_i0_r), .q_i1_r(q_i1_r), .q_i2_r(q_i2_r), .q_i3_r(q_i3_r), .q_u_r(q_u_r)
  );

  logic vx, vy, vz;
  crp_axis #(.MAX_POINTS(MAX_POINTS), .COORD_WIDTH(COORD_WIDTH),
    .T_FRAC_BITS(T_FRAC_BITS), .IDX_W(IDX_W)) u_ax (
    .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_idx(wr_idx), .wr_data(in_point_x),
    .rd_i0(q_i0_r), .rd_i1(q_i1_r), .rd_i2(q_i2_r), .rd_i3(q_i3_r), .u_in(q_u_r),
    .kind_in(q_kind_r), .vld_in(q_valid_r), .vld_out(vx), .pos_out(out_pos_x));
  crp_axis #(.MAX_POINTS(MAX_POINTS), .COORD_WIDTH(COORD_WIDTH),
    .T_FRAC_BITS(T_FRAC_BITS), .IDX_W(IDX_W)) u_ay (
    .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_idx(wr_idx), .wr_data(in_point_y),
    .rd_i0(q_i0_r), .rd_i1(q_i1_r), .rd_i2(q_i2_r), .rd_i3(q_i3_r), .u_in(q_u_r),
    .kind_in(q_kind_r), .vld_in(q_valid_r), .vld_out(vy), .pos_out(out_pos_y));
  crp_axis #(.MAX_POINTS(MAX_POINTS), .COORD_WIDTH(COORD_WIDTH),
    .T_FRAC_BITS(T_FRAC_BITS), .IDX_W(IDX_W)) u_az (
    .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_idx(wr_idx), .wr_data(in_point_z),
    .rd_i0(q_i0_r), .rd_i1(q_i1_r), .rd_i2(q_i2_r), .rd_i3(q_i3_r), .u_in(q_u_r),
    .kind_in(q_kind_r), .vld_in(q_valid_r), .vld_out(vz), .pos_out(out_pos_z));

  assign out_valid = vx;

  `CRP_ASSERT_IMPL(a_axes_agree, clk, rst_n, 1'b1, (vx == vy) && (vy == vz), "axis strobes differ")
  `CRP_ASSERT_NEXT(a_write_silent, clk, rst_n, take && in_cmd == crp_pkg::CMD_WRITE, !q_valid_r, "write made a request")
  `CRP_ASSERT_NEXT(a_eval_queued, clk, rst_n, take && in_cmd == crp_pkg::CMD_EVAL, q_valid_r, "evaluate dropped")
endmodule

FILE: sv/crp_front.sv
// Front end: takes requests, classifies evaluations and computes segment,
// neighbour indices and local t. Uses crp_pkg.
`timescale 1ns / 1ps
module crp_front #(
  parameter int unsigned MAX_POINTS  = 64,
  parameter int unsigned T_FRAC_BITS = 16,
  parameter int unsigned IDX_W       = 6
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             take,
  input  logic                             cmd,
  input  logic [crp_pkg::PtWidth-1:0]      param_t,
  input  logic [crp_pkg::CountWidth-1:0]   point_count,
  output logic                             q_valid_r,
  output crp_pkg::ev_kind_t                q_kind_r,
  output logic [IDX_W-1:0]                 q_i0_r,
  output logic [IDX_W-1:0]                 q_i1_r,
  output logic [IDX_W-1:0]                 q_i2_r,
  output logic [IDX_W-1:0]                 q_i3_r,
  output logic [T_FRAC_BITS:0]             q_u_r
);
  localparam int unsigned NW = (crp_pkg::CountWidth > IDX_W + 1) ?
                               crp_pkg::CountWidth : IDX_W + 1;
  localparam int unsigned SW = T_FRAC_BITS + 1 + NW;

  logic [NW-1:0]          n_c, segs_c;
  logic [T_FRAC_BITS:0]   t_c;
  logic [SW-1:0]          scaled_c;
  logic [NW-1:0]          seg_c, s_c;
  logic [T_FRAC_BITS:0]   u_c;
  logic [NW-1:0]          i0_c, i2_c, i3_c;
  crp_pkg::ev_kind_t      kind_c;

  // Clamp count and t, find segment and neighbours, classify the kind.
  always_comb begin
    n_c = NW'(point_count);
    if (n_c > NW'(MAX_POINTS)) begin
      n_c = NW'(MAX_POINTS);
    end
    segs_c = n_c - NW'(1);
    if (param_t[crp_pkg::PtWidth-1]) begin
      t_c = '0;
    end else if (32'(param_t[crp_pkg::PtWidth-2:0]) > 32'(1 << T_FRAC_BITS)) begin
      t_c = (T_FRAC_BITS+1)'(1 << T_FRAC_BITS);
    end else begin
      t_c = (T_FRAC_BITS+1)'(param_t[crp_pkg::PtWidth-2:0]);
    end
    scaled_c = SW'(t_c) * SW'(segs_c);
    seg_c    = NW'(scaled_c >> T_FRAC_BITS);
    if (seg_c >= segs_c) begin
      s_c = segs_c - NW'(1);
      u_c = (T_FRAC_BITS+1)'(1 << T_FRAC_BITS);
    end else begin
      s_c = seg_c;
      u_c = {1'b0, scaled_c[T_FRAC_BITS-1:0]};
    end
    i0_c = (s_c == '0) ? '0 : s_c - NW'(1);
    i2_c = (s_c + NW'(1) > segs_c) ? segs_c : s_c + NW'(1);
    i3_c = (s_c + NW'(2) > segs_c) ? segs_c : s_c + NW'(2);
    if (n_c == '0) begin
      kind_c = crp_pkg::EV_ZERO;
    end else if (n_c == NW'(1)) begin
      kind_c = crp_pkg::EV_SINGLE;
    end else begin
      kind_c = crp_pkg::EV_CURVE;
    end
  end

  // Register the classified request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r <= 1'b0;
    end else begin
      q_valid_r <= take && (cmd == crp_pkg::CMD_EVAL);
    end
    q_kind_r <= kind_c;
    q_u_r    <= u_c;
    if (kind_c == crp_pkg::EV_CURVE) begin
      q_i0_r <= IDX_W'(i0_c);
      q_i1_r <= IDX_W'(s_c);
      q_i2_r <= IDX_W'(i2_c);
      q_i3_r <= IDX_W'(i3_c);
    end else begin
      q_i0_r <= '0;
      q_i1_r <= '0;
      q_i2_r <= '0;
      q_i3_r <= '0;
    end
  end
endmodule

FILE: sv/crp_axis.sv
// Back end for one coordinate: point memory, four-port read by banking,
// and a pipelined Horner evaluation with saturation. Uses crp_pkg.
`timescale 1ns / 1ps
`include "catmull_rom_path_eval_defines.svh"
module crp_axis #(
  parameter int unsigned MAX_POINTS  = 64,
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned T_FRAC_BITS = 16,
  parameter int unsigned IDX_W       = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [IDX_W-1:0]              wr_idx,
  input  logic [COORD_WIDTH-1:0]        wr_data,
  input  logic [IDX_W-1:0]              rd_i0,
  input  logic [IDX_W-1:0]              rd_i1,
  input  logic [IDX_W-1:0]              rd_i2,
  input  logic [IDX_W-1:0]              rd_i3,
  input  logic [T_FRAC_BITS:0]          u_in,
  input  crp_pkg::ev_kind_t             kind_in,
  input  logic                          vld_in,
  output logic                          vld_out,
  output logic [COORD_WIDTH-1:0]        pos_out
);
  localparam int unsigned CW = COORD_WIDTH + 4;
  localparam int unsigned HW = COORD_WIDTH + 5;
  localparam int unsigned PW = HW + T_FRAC_BITS + 2;
  localparam int unsigned LAT = 5;

  // Two identical copies of the point memory, each read at two ports.
  logic [COORD_WIDTH-1:0] mem_a [MAX_POINTS];
  logic [COORD_WIDTH-1:0] mem_b [MAX_POINTS];
  logic signed [COORD_WIDTH-1:0] p0_r, p1_r, p2_r, p3_r;

  // Write both copies, read two ports of each.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[wr_idx] <= wr_data;
      mem_b[wr_idx] <= wr_data;
    end
    p0_r <= mem_a[rd_i0];
    p1_r <= mem_a[rd_i1];
    p2_r <= mem_b[rd_i2];
    p3_r <= mem_b[rd_i3];
  end

  logic [LAT-1:0]                vld_r;
  crp_pkg::ev_kind_t             k_r [LAT];
  logic [T_FRAC_BITS:0]          u_r [LAT];

  // Advance valid, kind and u down the pipe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], vld_in};
    end
    k_r[0] <= kind_in;
    u_r[0] <= u_in;
    for (int i = 1; i < LAT; i++) begin
      k_r[i] <= k_r[i-1];
      u_r[i] <= u_r[i-1];
    end
  end

  // Stage 1: coefficients.
  logic signed [CW-1:0] a_r, b_r, c_r, d_r;
  logic signed [CW-1:0] e0, e1, e2, e3;
  always_comb begin
    e0 = CW'(p0_r);
    e1 = CW'(p1_r);
    e2 = CW'(p2_r);
    e3 = CW'(p3_r);
  end
  always_ff @(posedge clk) begin
    a_r <= e1 <<< 1;
    b_r <= e2 - e0;
    c_r <= (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
    d_r <= (e1 <<< 1) + e1 - (e2 <<< 1) - e2 + e3 - e0;
  end

  // Stages 2-4: Horner steps, one multiply each.
  logic signed [CW-1:0] a1_r, b1_r, c1_r, a2_r, b2_r, a3_r;
  logic signed [HW-1:0] h1_r, h2_r, h3_r;
  logic signed [PW-1:0] m1, m2, m3;
  always_comb begin
    m1 = PW'(d_r) * $signed({1'b0, u_r[1]});
    m2 = (PW'(h1_r) + PW'(c1_r)) * $signed({1'b0, u_r[2]});
    m3 = (PW'(h2_r) + PW'(b2_r)) * $signed({1'b0, u_r[3]});
  end
  always_ff @(posedge clk) begin
    h1_r <= HW'(m1 >>> T_FRAC_BITS);
    c1_r <= c_r;
    b1_r <= b_r;
    a1_r <= a_r;
    h2_r <= HW'(m2 >>> T_FRAC_BITS);
    b2_r <= b1_r;
    a2_r <= a1_r;
    h3_r <= HW'(m3 >>> T_FRAC_BITS);
    a3_r <= a2_r;
  end

  // Stage 5: halve, saturate and pick by kind.
  logic signed [HW:0] f_c;
  logic signed [COORD_WIDTH-1:0] sat_c;
  localparam logic signed [HW:0] HiLim = (HW+1)'({1'b0, {(COORD_WIDTH-1){1'b1}}});
  localparam logic signed [HW:0] LoLim = -HiLim - (HW+1)'(1);
  always_comb begin
    f_c = ((HW+1)'(h3_r) + (HW+1)'(a3_r)) >>> 1;
    if (f_c > HiLim) begin
      sat_c = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end else if (f_c < LoLim) begin
      sat_c = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      sat_c = COORD_WIDTH'(f_c);
    end
  end

  logic [COORD_WIDTH-1:0] pos_r;
  logic signed [COORD_WIDTH-1:0] p1_d_r [LAT-1];
  always_ff @(posedge clk) begin
    p1_d_r[0] <= p1_r;
    for (int i = 1; i < LAT - 1; i++) begin
      p1_d_r[i] <= p1_d_r[i-1];
    end
    case (k_r[LAT-1])
      crp_pkg::EV_ZERO:   pos_r <= '0;
      crp_pkg::EV_SINGLE: pos_r <= p1_d_r[LAT-2];
      crp_pkg::EV_CURVE:  pos_r <= sat_c;
      default:            pos_r <= '0;
    endcase
  end
  assign pos_out = pos_r;

  logic vout_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vout_r <= 1'b0;
    end else begin
      vout_r <= vld_r[LAT-1];
    end
  end
  assign vld_out = vout_r;

  `CRP_ASSERT_NEXT(a_vld_flow, clk, rst_n, vld_r[LAT-1], vld_out, "result strobe lost")
  `CRP_ASSERT_NEXT(a_zero_out, clk, rst_n, vld_r[LAT-1] && k_r[LAT-1] == crp_pkg::EV_ZERO, pos_out == '0, "empty path gave nonzero")
  `CRP_ASSERT_IMPL(a_u_range, clk, rst_n, vld_r[1], u_r[1] <= (T_FRAC_BITS+1)'(1 << T_FRAC_BITS), "local t above one")
endmodule
